/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define RCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define RCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rct_pkg;

    localparam int RCT_TABLE_ENTRIES = 64;

    localparam logic [1:0] CMD_INCREMENT = 2'd0;
    localparam logic [1:0] CMD_DECREMENT = 2'd1;
    localparam logic [1:0] CMD_QUERY     = 2'd2;

    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_FULL          = 2'd1;
    localparam logic [1:0] ST_GEN_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] object_key;
        logic [63:0] amount;
    } rct_in_t;

    typedef struct packed {
        logic        has_generation;
        logic [63:0] generation;
        logic        is_nonzero;
        logic [1:0]  status;
    } rct_out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LOOKUP,
        S_EXEC
    } rct_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic lookup;
        logic exec;
    } rct_ctrl_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } rct_stat_t;

endpackage

`default_nettype wire

/* rtl/core/rct_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rct_ctrl
    import rct_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire rct_stat_t stat,
    output rct_ctrl_t      ctrl
);

    rct_state_t state_reg;
    rct_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.scan_done) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl    = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready   = 1'b1;
                ctrl.load = s_valid;
            end
            S_SCAN: begin
                ctrl.scan = 1'b1;
            end
            S_LOOKUP: begin
                ctrl.lookup = 1'b1;
            end
            S_EXEC: begin
                ctrl.exec = stat.out_free;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/rct_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module rct_datapath
    import rct_pkg::*;
#(
    parameter int TABLE_ENTRIES = RCT_TABLE_ENTRIES
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire rct_in_t   s_data,
    input  wire rct_ctrl_t ctrl,
    output rct_stat_t      stat,
    output logic           m_valid,
    input  wire logic      m_ready,
    output rct_out_t       m_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W:0] ENTRIES = (IDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [IDX_W:0] IDX_ONE = (IDX_W + 1)'(1);

    logic [63:0] key_mem [TABLE_ENTRIES];
    logic [63:0] cnt_mem [TABLE_ENTRIES];
    logic [63:0] gen_mem [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [63:0]              next_gen_reg;

    rct_in_t     item_reg;
    logic [IDX_W:0]   rd_idx_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg;
    logic [63:0]      key_rd_reg;
    logic             found_reg;
    logic [IDX_W-1:0] slot_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [63:0]      cnt_rd_reg;
    logic [63:0]      gen_rd_reg;

    logic     m_valid_reg;
    rct_out_t m_data_reg;

    rct_out_t         res;
    logic             cnt_we;
    logic             ins;
    logic             vld_clr;
    logic [IDX_W-1:0] wr_addr;
    logic [63:0]      cnt_wdata;
    logic [63:0]      dec_cnt;
    logic             rd_in_range;

    assign rd_in_range    = (rd_idx_reg < ENTRIES);
    assign stat.scan_done = !rd_in_range && !cmp_vld_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;

    // scan: the compare sees each entry the cycle after its read address is issued
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (ctrl.load) begin
            rd_idx_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (ctrl.scan) begin
            cmp_vld_reg <= rd_in_range;
            if (rd_in_range) begin
                rd_idx_reg <= rd_idx_reg + IDX_ONE;
            end
            if (cmp_vld_reg) begin
                if (valid_reg[cmp_idx_reg] && key_rd_reg == item_reg.object_key) begin
                    found_reg <= 1'b1;
                end
                if (!valid_reg[cmp_idx_reg] && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            item_reg <= s_data;
            slot_reg <= '0;
        end else if (ctrl.scan && cmp_vld_reg) begin
            if (valid_reg[cmp_idx_reg] && key_rd_reg == item_reg.object_key) begin
                slot_reg <= cmp_idx_reg;
            end
            if (!valid_reg[cmp_idx_reg] && !free_found_reg) begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
        if (ctrl.scan) begin
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.scan) begin
            key_rd_reg <= key_mem[rd_idx_reg[IDX_W-1:0]];
        end
        if (ctrl.exec && ins) begin
            key_mem[wr_addr] <= item_reg.object_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.lookup) begin
            cnt_rd_reg <= cnt_mem[slot_reg];
        end
        if (ctrl.exec && cnt_we) begin
            cnt_mem[wr_addr] <= cnt_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.lookup) begin
            gen_rd_reg <= gen_mem[slot_reg];
        end
        if (ctrl.exec && ins) begin
            gen_mem[wr_addr] <= next_gen_reg;
        end
    end

    assign dec_cnt = (item_reg.amount >= cnt_rd_reg) ? 64'd0 : cnt_rd_reg - item_reg.amount;

    always_comb begin
        res       = '0;
        cnt_we    = 1'b0;
        ins       = 1'b0;
        vld_clr   = 1'b0;
        wr_addr   = slot_reg;
        cnt_wdata = cnt_rd_reg;
        case (item_reg.command)
            CMD_INCREMENT: begin
                if (found_reg) begin
                    cnt_we = 1'b1;
                    if (cnt_rd_reg != '1) begin
                        cnt_wdata = cnt_rd_reg + 64'd1;
                    end
                end else if (next_gen_reg == 64'd0) begin
                    res.status = ST_GEN_EXHAUSTED;
                end else if (!free_found_reg) begin
                    res.status = ST_FULL;
                end else begin
                    ins                = 1'b1;
                    cnt_we             = 1'b1;
                    wr_addr            = free_idx_reg;
                    cnt_wdata          = 64'd1;
                    res.has_generation = 1'b1;
                    res.generation     = next_gen_reg;
                end
            end
            CMD_DECREMENT: begin
                if (found_reg) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = dec_cnt;
                    if (dec_cnt == 64'd0) begin
                        vld_clr            = 1'b1;
                        res.has_generation = 1'b1;
                        res.generation     = gen_rd_reg;
                    end
                end
            end
            CMD_QUERY: begin
                res.is_nonzero = found_reg && (cnt_rd_reg != 64'd0);
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            next_gen_reg <= 64'd1;
        end else if (ctrl.exec) begin
            if (ins) begin
                valid_reg[wr_addr] <= 1'b1;
                next_gen_reg       <= next_gen_reg + 64'd1;
            end
            if (vld_clr) begin
                valid_reg[wr_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            m_data_reg <= res;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/refcount_table_with_generations.sv */
`timescale 1ns / 1ps
`default_nettype none

// Reference-count table keyed by 64-bit object number, TABLE_ENTRIES entries deep.
// One transfer in gives exactly one transfer out. After acceptance, the key lookup
// walks the key memory one entry per cycle through its single read port; the read
// is registered before the compare, and the end of the walk is then seen. Next the
// count and generation memories are read, and last the entry is updated and the
// result register loaded. That last step waits while an earlier result still sits
// untaken in the result register. A new item is taken once the previous one has
// reached the result register, even if that result is not yet taken.
// Inserts use the lowest free entry; a full table answers status 1 and a spent
// generation counter answers status 2, with nothing changed. No clearing pass is
// needed after reset.
module refcount_table_with_generations
    import rct_pkg::*;
#(
    parameter int TABLE_ENTRIES = RCT_TABLE_ENTRIES
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire rct_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output rct_out_t     m_data
);

    rct_ctrl_t ctrl;
    rct_stat_t stat;

    rct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    rct_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctrl    (ctrl),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

/* rtl/core/rct_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rct_checker
    import rct_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire rct_out_t m_data
);

    logic in_xfer;
    logic res_nogen;
    logic res_err;
    logic res_clean;

    assign in_xfer   = s_valid && s_ready;
    assign res_nogen = m_valid && !m_data.has_generation;
    assign res_err   = m_valid && (m_data.status != ST_OK);
    assign res_clean = !m_data.has_generation && !m_data.is_nonzero
                       && (m_data.status == ST_FULL || m_data.status == ST_GEN_EXHAUSTED);

    `RCT_ASSERT_NEXT(a_m_valid_hold, m_valid && !m_ready, m_valid, "result dropped")

    `RCT_ASSERT_NEXT(a_one_in_flight, in_xfer, !s_ready, "second item taken while busy")

    `RCT_ASSERT_NEXT(a_no_instant_result, in_xfer, !$rose(m_valid), "result too early")

    `RCT_ASSERT_NOW(a_gen_zero, res_nogen, m_data.generation == 64'd0, "stale generation")

    `RCT_ASSERT_NOW(a_err_clean, res_err, res_clean, "bad error result")

endmodule

bind refcount_table_with_generations rct_checker u_rct_checker (.*);

`default_nettype wire

/* tb/sv/rct_checker.sv */
`timescale 1ns / 1ps

module rct_scoreboard
    import rct_pkg::*;
#(
    parameter int TABLE_ENTRIES = RCT_TABLE_ENTRIES
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  rct_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  rct_out_t m_data,
    output int       fail_count,
    output int       outstanding
);

    logic        tbl_valid [TABLE_ENTRIES];
    logic [63:0] tbl_key   [TABLE_ENTRIES];
    logic [63:0] tbl_count [TABLE_ENTRIES];
    logic [63:0] tbl_gen   [TABLE_ENTRIES];
    logic [63:0] gen_next;

    rct_out_t pending_answers[$];
    int       errors = 0;

    assign fail_count = errors;

    function automatic rct_out_t refcount_update(rct_in_t cmd);
        rct_out_t res;
        int       hit;
        int       slot;
        res  = '0;
        hit  = -1;
        slot = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == cmd.object_key) begin
                hit = i;
            end
        end
        case (cmd.command)
            CMD_INCREMENT: begin
                if (hit >= 0) begin
                    if (tbl_count[hit] != '1) begin
                        tbl_count[hit] = tbl_count[hit] + 64'd1;
                    end
                end else if (gen_next == '0) begin
                    res.status = ST_GEN_EXHAUSTED;
                end else begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (slot < 0 && !tbl_valid[i]) begin
                            slot = i;
                        end
                    end
                    if (slot < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        tbl_valid[slot]    = 1'b1;
                        tbl_key[slot]      = cmd.object_key;
                        tbl_count[slot]    = 64'd1;
                        tbl_gen[slot]      = gen_next;
                        res.has_generation = 1'b1;
                        res.generation     = gen_next;
                        gen_next           = gen_next + 64'd1;
                    end
                end
            end
            CMD_DECREMENT: begin
                if (hit >= 0) begin
                    if (cmd.amount >= tbl_count[hit]) begin
                        tbl_count[hit] = '0;
                    end else begin
                        tbl_count[hit] = tbl_count[hit] - cmd.amount;
                    end
                    if (tbl_count[hit] == '0) begin
                        res.has_generation = 1'b1;
                        res.generation     = tbl_gen[hit];
                        tbl_valid[hit]     = 1'b0;
                    end
                end
            end
            CMD_QUERY: begin
                res.is_nonzero = (hit >= 0) && (tbl_count[hit] != '0);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        rct_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_key[i]   = '0;
                tbl_count[i] = '0;
                tbl_gen[i]   = '0;
            end
            gen_next = 64'd1;
            pending_answers.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_answers.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    want = pending_answers.pop_front();
                    if (m_data.has_generation !== want.has_generation) begin
                        $error("has_generation: expected %0d, actual %0d",
                               want.has_generation, m_data.has_generation);
                        errors++;
                    end
                    if (m_data.generation !== want.generation) begin
                        $error("generation: expected %h, actual %h",
                               want.generation, m_data.generation);
                        errors++;
                    end
                    if (m_data.is_nonzero !== want.is_nonzero) begin
                        $error("is_nonzero: expected %0d, actual %0d",
                               want.is_nonzero, m_data.is_nonzero);
                        errors++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, m_data.status);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                want            = refcount_update(s_data);
                pending_answers = {pending_answers, want};
            end
        end
        outstanding <= pending_answers.size();
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import rct_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int POOL_SIZE  = 96;
    localparam int CYCLE_LIMIT = 900_000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    rct_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    rct_out_t m_data;

    int fail_count;
    int outstanding;
    int sent_count;
    int cycle_count = 0;
    logic calm;

    logic [63:0] key_pool [POOL_SIZE];

    refcount_table_with_generations u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    rct_scoreboard u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_amount();
        case ($urandom_range(4))
            0:       return '0;
            1:       return 64'd1;
            2:       return 64'($urandom_range(2, 5));
            3:       return rand64();
            default: return '1;
        endcase
    endfunction

    function automatic rct_in_t mixed_item(int inc_pct, int dec_pct);
        rct_in_t it;
        int      r;
        r = $urandom_range(99);
        if (r < 2) begin
            it.command = CMD_UNUSED;
        end else if (r < 2 + inc_pct) begin
            it.command = CMD_INCREMENT;
        end else if (r < 2 + inc_pct + dec_pct) begin
            it.command = CMD_DECREMENT;
        end else begin
            it.command = CMD_QUERY;
        end
        if ($urandom_range(9) == 0) begin
            it.object_key = rand64();
        end else begin
            it.object_key = key_pool[$urandom_range(POOL_SIZE - 1)];
        end
        it.amount = pick_amount();
        return it;
    endfunction

    // holds valid across back-to-back transfers; returns at the accepting edge
    task automatic send(input rct_in_t it);
        if (!calm && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [63:0] key,
                            input logic [63:0] amt);
        rct_in_t it;
        it.command    = cmd;
        it.object_key = key;
        it.amount     = amt;
        send(it);
    endtask

    // receiver: random stalls, plus one long hold-off to back up the input
    initial begin
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (!held && sent_count >= 150) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (500) @(posedge aclk);
            end else if (!calm && $urandom_range(999) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 120)) @(posedge aclk);
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 3);
            end
        end
    end

    initial begin
        rct_in_t it;
        int      base;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        calm       = 1'b0;
        sent_count = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = rand64();
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_cmd(CMD_QUERY,     '0, '0);
        send_cmd(CMD_DECREMENT, '1, 64'd5);
        send_cmd(CMD_INCREMENT, '0, '0);
        send_cmd(CMD_INCREMENT, '0, '1);
        send_cmd(CMD_QUERY,     '0, '0);
        send_cmd(CMD_DECREMENT, '0, '0);
        send_cmd(CMD_DECREMENT, '0, 64'd1);
        send_cmd(CMD_INCREMENT, '1, '0);
        send_cmd(CMD_UNUSED,    '1, '1);
        send_cmd(CMD_QUERY,     '1, '1);
        send_cmd(CMD_DECREMENT, '1, '1);
        send_cmd(CMD_DECREMENT, '0, 64'd1);
        send_cmd(CMD_QUERY,     '0, '0);
        send_cmd(CMD_INCREMENT, 64'h5555_5555_5555_5555, '1);
        send_cmd(CMD_INCREMENT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_cmd(CMD_QUERY,     64'hAAAA_AAAA_AAAA_AAAA, '1);
        send_cmd(CMD_DECREMENT, 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0000);
        send_cmd(CMD_DECREMENT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h7FFF_FFFF_FFFF_FFFF);
        send_cmd(CMD_QUERY,     64'h5555_5555_5555_5555, '0);

        for (int round = 0; round < 3; round++) begin
            base = $urandom_range(POOL_SIZE - 1);
            // fill past capacity so inserts hit the full table
            for (int i = 0; i < 72; i++) begin
                if ($urandom_range(9) == 0) begin
                    it = mixed_item(40, 35);
                end else begin
                    it.command    = CMD_INCREMENT;
                    it.object_key = key_pool[(base + i) % POOL_SIZE];
                    it.amount     = rand64();
                end
                send(it);
            end
            calm = (round == 1);
            for (int i = 0; i < 100; i++) begin
                send(mixed_item(40, 35));
            end
            calm = 1'b0;
            // drain
            for (int i = 0; i < 72; i++) begin
                if ($urandom_range(9) == 0) begin
                    it = mixed_item(30, 40);
                end else begin
                    it.command    = CMD_DECREMENT;
                    it.object_key = key_pool[(base + i) % POOL_SIZE];
                    case ($urandom_range(2))
                        0:       it.amount = '1;
                        1:       it.amount = 64'($urandom_range(1, 3));
                        default: it.amount = rand64();
                    endcase
                end
                send(it);
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
